@@ hw/rtl/cmr_pkg.sv @@
// ----------------------------------------------------------------------------
// cmr_pkg
// Shared widths and item types for the complex modulus replacement block.
// ----------------------------------------------------------------------------
package cmr_pkg;

    localparam int W   = 24;      // sample width
    localparam int F   = 16;      // fraction bits
    localparam int W2  = 2 * W;   // square / product width
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // classified sample as handed from front to back
    typedef struct packed {
        logic [W-1:0]  re_abs;
        logic [W-1:0]  im_abs;
        logic          re_neg;
        logic          im_neg;
        logic [W-1:0]  target;
        logic [W2-1:0] sumsq;
        logic          last;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

@@ hw/rtl/cmr_front.sv @@
// ----------------------------------------------------------------------------
// cmr_front
// Accepts samples, splits sign and magnitude and forms re^2 + im^2.
// ----------------------------------------------------------------------------
module cmr_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [cmr_pkg::W-1:0]     i_re,
    input  logic [cmr_pkg::W-1:0]     i_im,
    input  logic [cmr_pkg::W-1:0]     i_target,
    input  logic                      i_last,
    input  cmr_pkg::t_fifo_stat       i_stat,
    output logic                      o_push,
    output cmr_pkg::t_item            o_item
);

    logic           r_v;
    cmr_pkg::t_item r_item;
    cmr_pkg::t_item n_item;
    logic [cmr_pkg::W-1:0] re_abs;
    logic [cmr_pkg::W-1:0] im_abs;

    assign o_ready = !r_v || !i_stat.full;
    assign o_push  = r_v && !i_stat.full;
    assign o_item  = r_item;

    // two's complement negate also covers the most negative value
    assign re_abs = i_re[cmr_pkg::W-1] ? (~i_re + 1'b1) : i_re;
    assign im_abs = i_im[cmr_pkg::W-1] ? (~i_im + 1'b1) : i_im;

    always_comb begin
        n_item.re_abs = re_abs;
        n_item.im_abs = im_abs;
        n_item.re_neg = i_re[cmr_pkg::W-1];
        n_item.im_neg = i_im[cmr_pkg::W-1];
        n_item.target = i_target;
        n_item.sumsq  = cmr_pkg::W2'(re_abs) * cmr_pkg::W2'(re_abs)
                      + cmr_pkg::W2'(im_abs) * cmr_pkg::W2'(im_abs);
        n_item.last   = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

@@ hw/rtl/cmr_fifo.sv @@
// ----------------------------------------------------------------------------
// cmr_fifo
// Short queue of classified samples between front and back.
// ----------------------------------------------------------------------------
module cmr_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  cmr_pkg::t_item       i_item,
    input  logic                 i_pop_req,
    output logic                 o_pop,
    output cmr_pkg::t_item       o_item,
    output cmr_pkg::t_fifo_stat  o_stat
);

    cmr_pkg::t_item                r_mem [cmr_pkg::FIFO_DEPTH];
    logic [cmr_pkg::FIFO_AW-1:0]   r_wp;
    logic [cmr_pkg::FIFO_AW-1:0]   r_rp;
    logic [cmr_pkg::FIFO_AW:0]     r_cnt;

    assign o_stat.full  = (r_cnt == (cmr_pkg::FIFO_AW+1)'(cmr_pkg::FIFO_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_pop        = i_pop_req && !o_stat.empty;
    assign o_item       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (o_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (cmr_pkg::FIFO_AW+1)'(i_push) - (cmr_pkg::FIFO_AW+1)'(o_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

@@ hw/rtl/cmr_back.sv @@
// ----------------------------------------------------------------------------
// cmr_back
// Pipelined square root, scaling product, restoring division and saturation.
// ----------------------------------------------------------------------------
module cmr_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    output logic                  o_pop_req,
    input  logic                  i_pop,
    input  cmr_pkg::t_item        i_item,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [cmr_pkg::W-1:0] o_re,
    output logic [cmr_pkg::W-1:0] o_im,
    output logic                  o_last
);

    localparam int W   = cmr_pkg::W;
    localparam int W2  = cmr_pkg::W2;
    localparam int SQN = W;    // one root bit per stage
    localparam int DVN = W2;   // one quotient bit per stage
    localparam logic [W-1:0]  ONE   = W'(1) << cmr_pkg::F;
    localparam logic [W2-1:0] SMAX  = (W2'(1) << (W - 1)) - 1'b1;
    localparam logic [W2-1:0] SMINM = W2'(1) << (W - 1);

    logic en;

    // square root stages
    logic          r_sv   [SQN+1];
    logic [W+1:0]  r_srem [SQN+1];
    logic [W-1:0]  r_root [SQN+1];
    logic [W2-1:0] r_rad  [SQN+1];
    logic [W-1:0]  r_sre  [SQN+1];
    logic [W-1:0]  r_sim  [SQN+1];
    logic [W-1:0]  r_stg  [SQN+1];
    logic [1:0]    r_sneg [SQN+1];
    logic          r_slst [SQN+1];

    // division stages, one lane per part
    logic          r_dv   [DVN+1];
    logic [W-1:0]  r_div  [DVN+1];
    logic [W-1:0]  r_rrem [DVN+1];
    logic [W2-1:0] r_rq   [DVN+1];
    logic [W-1:0]  r_irem [DVN+1];
    logic [W2-1:0] r_iq   [DVN+1];
    logic [1:0]    r_dneg [DVN+1];
    logic          r_dlst [DVN+1];

    logic          r_ov;
    logic [W-1:0]  r_ore;
    logic [W-1:0]  r_oim;
    logic          r_olst;

    logic [W-1:0]  mag;
    logic [W-1:0]  sat_re;
    logic [W-1:0]  sat_im;

    assign en        = !r_ov || i_ready;
    assign o_pop_req = en;
    assign o_valid   = r_ov;
    assign o_re      = r_ore;
    assign o_im      = r_oim;
    assign o_last    = r_olst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= SQN; k++) r_sv[k] <= 1'b0;
            for (int j = 0; j <= DVN; j++) r_dv[j] <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_sv[0] <= i_pop;
            for (int k = 0; k < SQN; k++) r_sv[k+1] <= r_sv[k];
            r_dv[0] <= r_sv[SQN];
            for (int j = 0; j < DVN; j++) r_dv[j+1] <= r_dv[j];
            r_ov <= r_dv[DVN];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_srem[0] <= '0;
            r_root[0] <= '0;
            r_rad[0]  <= i_item.sumsq;
            r_sre[0]  <= i_item.re_abs;
            r_sim[0]  <= i_item.im_abs;
            r_stg[0]  <= i_item.target;
            r_sneg[0] <= {i_item.im_neg, i_item.re_neg};
            r_slst[0] <= i_item.last;
        end
    end

    genvar k;
    generate
        for (k = 0; k < SQN; k++) begin : g_sqrt
            logic [W+3:0] pre;
            logic [W+3:0] trial;
            logic         take;
            assign pre   = {r_srem[k], r_rad[k][W2-1 -: 2]};
            assign trial = (W+4)'({r_root[k], 2'b01});
            assign take  = (pre >= trial);
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_srem[k+1] <= take ? (W+2)'(pre - trial) : (W+2)'(pre);
                    r_root[k+1] <= {r_root[k][W-2:0], take};
                    r_rad[k+1]  <= {r_rad[k][W2-3:0], 2'b00};
                    r_sre[k+1]  <= r_sre[k];
                    r_sim[k+1]  <= r_sim[k];
                    r_stg[k+1]  <= r_stg[k];
                    r_sneg[k+1] <= r_sneg[k];
                    r_slst[k+1] <= r_slst[k];
                end
            end
        end
    endgenerate

    // zero magnitude divides by one
    assign mag = (r_root[SQN] == '0) ? ONE : r_root[SQN];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_div[0]  <= mag;
            r_rrem[0] <= '0;
            r_irem[0] <= '0;
            r_rq[0]   <= W2'(r_sre[SQN]) * W2'(r_stg[SQN]);
            r_iq[0]   <= W2'(r_sim[SQN]) * W2'(r_stg[SQN]);
            r_dneg[0] <= r_sneg[SQN];
            r_dlst[0] <= r_slst[SQN];
        end
    end

    genvar j;
    generate
        for (j = 0; j < DVN; j++) begin : g_div
            logic [W:0] rt;
            logic [W:0] it;
            logic       rtk;
            logic       itk;
            assign rt  = {r_rrem[j], r_rq[j][W2-1]};
            assign it  = {r_irem[j], r_iq[j][W2-1]};
            assign rtk = (rt >= {1'b0, r_div[j]});
            assign itk = (it >= {1'b0, r_div[j]});
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_rrem[j+1] <= rtk ? W'(rt - {1'b0, r_div[j]}) : W'(rt);
                    r_irem[j+1] <= itk ? W'(it - {1'b0, r_div[j]}) : W'(it);
                    r_rq[j+1]   <= {r_rq[j][W2-2:0], rtk};
                    r_iq[j+1]   <= {r_iq[j][W2-2:0], itk};
                    r_div[j+1]  <= r_div[j];
                    r_dneg[j+1] <= r_dneg[j];
                    r_dlst[j+1] <= r_dlst[j];
                end
            end
        end
    endgenerate

    function automatic logic [W-1:0] saturate(input logic [W2-1:0] q, input logic neg);
        logic [W2-1:0] c;
        begin
            if (!neg) begin
                saturate = (q > SMAX) ? W'(SMAX) : W'(q);
            end else begin
                c = (q > SMINM) ? SMINM : q;
                saturate = W'(~c + 1'b1);
            end
        end
    endfunction

    assign sat_re = saturate(r_rq[DVN], r_dneg[DVN][0]);
    assign sat_im = saturate(r_iq[DVN], r_dneg[DVN][1]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ore  <= sat_re;
            r_oim  <= sat_im;
            r_olst <= r_dlst[DVN];
        end
    end

endmodule

@@ hw/rtl/complex_modulus_replace.sv @@
// ----------------------------------------------------------------------------
// complex_modulus_replace
// Replaces the modulus of each complex sample by a target and keeps its phase.
// ----------------------------------------------------------------------------
// Takes one sample per clock and gives one result per clock when the output
// side does not stall. A sample passes through the front register, the queue,
// 25 square-root registers (an input register and 24 stages of one root bit
// each), 49 division registers (an input register and 48 stages of one
// quotient bit each, two lanes) and the output register. An output stall
// holds the whole back pipeline; the queue then fills and the input stalls.
// Fixed point is signed 24 bits with 16 fraction bits, results are truncated
// toward zero and saturated; a zero sample gives zero.
module complex_modulus_replace (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,   // re_in, im_in, target_modulus
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // re_out, im_out
    output logic        o_m_tlast
);

    localparam int W = cmr_pkg::W;

    cmr_pkg::t_item      front_item;
    cmr_pkg::t_item      fifo_item;
    cmr_pkg::t_fifo_stat stat;
    logic                push;
    logic                pop;
    logic                pop_req;

    cmr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_re     (i_s_tdata[W-1:0]),
        .i_im     (i_s_tdata[2*W-1:W]),
        .i_target (i_s_tdata[3*W-1:2*W]),
        .i_last   (i_s_tlast),
        .i_stat   (stat),
        .o_push   (push),
        .o_item   (front_item)
    );

    cmr_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_item    (front_item),
        .i_pop_req (pop_req),
        .o_pop     (pop),
        .o_item    (fifo_item),
        .o_stat    (stat)
    );

    cmr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .o_pop_req (pop_req),
        .i_pop     (pop),
        .i_item    (fifo_item),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_re      (o_m_tdata[W-1:0]),
        .o_im      (o_m_tdata[2*W-1:W]),
        .o_last    (o_m_tlast)
    );

    a_fifo_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(stat.full && stat.empty))
        else $error("queue full and empty at once");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.full && !pop |=> stat.full)
        else $error("queue left full without a pop");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !stat.full)
        else $error("push into full queue");

endmodule

@@ tb/complex_modulus_replace_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_modulus_replace_chk
// Watches both stream channels of the modulus replacement block, works out the
// expected scaled sample for each accepted input beat and compares the output
// beats in order against it.
// ----------------------------------------------------------------------------
module complex_modulus_replace_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [71:0] i_s_tdata,   // re_in, im_in, target_modulus
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [47:0] i_m_tdata,   // re_out, im_out
    input  logic        i_m_tlast,
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);
    localparam int W = cmr_pkg::W;
    localparam int F = cmr_pkg::F;

    typedef struct {
        logic [W-1:0] re;
        logic [W-1:0] im;
        logic         last;
    } t_scaled;

    t_scaled scaled_q[$];

    function automatic logic [63:0] isqrt(logic [63:0] n);
        logic [63:0] r;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= n)
                r = r | (64'd1 << b);
        end
        return r;
    endfunction

    function automatic logic [W-1:0] scale(logic [W-1:0] x, logic [W-1:0] tgt,
                                           logic [63:0] mag);
        logic        neg;
        logic [63:0] a;
        logic [63:0] q;
        neg = x[W-1];
        a = neg ? 64'((~x) + 1'b1) & ((64'd1 << W) - 1) : 64'(x);
        q = (a * 64'(tgt)) / mag;
        if (!neg) begin
            if (q > (64'd1 << (W - 1)) - 1) q = (64'd1 << (W - 1)) - 1;
            return q[W-1:0];
        end
        if (q > (64'd1 << (W - 1))) q = 64'd1 << (W - 1);
        return W'(~q + 1);
    endfunction

    function automatic t_scaled predict(logic [71:0] d, logic lst);
        t_scaled     s;
        logic [63:0] ra;
        logic [63:0] ia;
        logic [63:0] mag;
        ra = d[W-1] ? 64'(W'(~d[W-1:0] + 1'b1)) : 64'(d[W-1:0]);
        if (d[W-1] && d[W-2:0] == 0) ra = 64'd1 << (W - 1);
        ia = d[2*W-1] ? 64'(W'(~d[2*W-1:W] + 1'b1)) : 64'(d[2*W-1:W]);
        if (d[2*W-1] && d[2*W-2:W] == 0) ia = 64'd1 << (W - 1);
        mag = isqrt(ra * ra + ia * ia);
        if (mag == 0) mag = 64'd1 << F;
        s.re   = scale(d[W-1:0], d[3*W-1:2*W], mag);
        s.im   = scale(d[2*W-1:W], d[3*W-1:2*W], mag);
        s.last = lst;
        return s;
    endfunction

    always @(posedge i_clk) begin
        t_scaled e;
        if (i_rst_n && i_s_tvalid && i_s_tready)
            scaled_q.push_back(predict(i_s_tdata, i_s_tlast));
        if (i_rst_n && i_m_tvalid && i_m_tready) begin
            o_results++;
            if (scaled_q.size() == 0) begin
                $error("result beat with nothing expected: %h", i_m_tdata);
                o_errors++;
            end else begin
                e = scaled_q.pop_front();
                if (i_m_tdata[W-1:0] !== e.re) begin
                    $error("re_out expected %h got %h", e.re, i_m_tdata[W-1:0]);
                    o_errors++;
                end
                if (i_m_tdata[2*W-1:W] !== e.im) begin
                    $error("im_out expected %h got %h", e.im, i_m_tdata[2*W-1:W]);
                    o_errors++;
                end
                if (i_m_tlast !== e.last) begin
                    $error("last_out expected %b got %b", e.last, i_m_tlast);
                    o_errors++;
                end
            end
        end
        o_pending = scaled_q.size();
    end
endmodule

@@ tb/complex_modulus_replace_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_modulus_replace_tb
// Streams directed and random complex samples with target moduli through the
// block under varying valid and ready gaps; the checker compares every result.
// ----------------------------------------------------------------------------
module complex_modulus_replace_tb;
    localparam int N_RANDOM = 1000;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 100;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // re_in, im_in, target_modulus
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // re_out, im_out
    logic        m_tlast;
    int          errors;
    int          pending;
    int          results;
    int          cycles;
    int          sender_idle_pct;
    int          receiver_idle_pct;
    int          n_sent;

    complex_modulus_replace dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tlast(s_tlast),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(m_tdata), .o_m_tlast(m_tlast)
    );

    complex_modulus_replace_chk chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tlast(s_tlast),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tlast(m_tlast),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // receiver stalls at random
    always @(negedge i_clk)
        m_tready <= i_rst_n && ($urandom_range(99) >= receiver_idle_pct);

    // valid stays up after the accepting edge; the next call or the caller drops it
    task automatic send(logic [23:0] re, logic [23:0] im, logic [23:0] tgt,
                        logic lst);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 0;
            @(negedge i_clk);
        end
        s_tvalid <= 1;
        s_tdata  <= {tgt, im, re};
        s_tlast  <= lst;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
        n_sent++;
    endtask

    function automatic logic [23:0] rnd_part();
        case ($urandom_range(3))
            0: return 24'($signed(8'($urandom)));
            1: return 24'($signed(16'($urandom)));
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin
        logic [23:0] edges[6] = '{24'h000000, 24'h000001, 24'h7fffff,
                                  24'h800000, 24'hffffff, 24'h010000};
        i_rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tlast = 0;
        m_tready = 0;
        n_sent = 0;
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // zero sample, extremes, most negative parts, saturation
        send(24'h0, 24'h0, 24'hffffff, 1);
        send(24'h0, 24'h0, 24'h0, 0);
        for (int k = 0; k < 6; k++)
            send(edges[k], edges[(k + 2) % 6], (k % 2) ? 24'hffffff : 24'h010000, k == 5);
        send(24'h800000, 24'h800000, 24'hffffff, 0);
        send(24'h800000, 24'h0, 24'h7fffff, 0);
        send(24'h000001, 24'h0, 24'hffffff, 1);
        send(24'hffffff, 24'h0, 24'hffffff, 0);
        send(24'h7fffff, 24'h7fffff, 24'h000001, 0);
        send(24'h000003, 24'hfffffc, 24'h050000, 1);
        s_tvalid <= 0;

        // hold off until the pipeline has drained
        while (pending != 0) @(negedge i_clk);

        for (int p = 0; p < 3; p++) begin
            sender_idle_pct   = (p == 0) ? 20 : (p == 1) ? 82 : 0;
            receiver_idle_pct = (p == 0) ? 82 : (p == 1) ? 20 : 0;
            for (int n = 0; n < N_RANDOM / 3; n++)
                send(rnd_part(), rnd_part(),
                     ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(24'h40000)),
                     $urandom_range(7) == 0);
        end
        s_tvalid <= 0;

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("sent %0d samples, checked %0d results over three stall profiles",
                 n_sent, results);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
